// ===== rtl/core/dst_pkg.sv =====
package dst_pkg;

	localparam int COORD_FRAC_DEF = 8;
	localparam int GAIN_FRAC_DEF  = 16;

	localparam int CW = 24;
	localparam int MW = 25;
	localparam int PW = 50;
	localparam int SW = 52;
	localparam int UW = 6;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] anchor_x;
		logic signed [23:0] anchor_y;
	} cmd_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [1:0]         mode;
		logic               spawned;
	} res_t;

	typedef struct packed {
		logic [15:0] spring_gain;
		logic [15:0] damping_factor;
		logic [22:0] detach_distance;
	} cfg_t;

	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_UPDATE = 3'd1;
	localparam logic [2:0] OP_END    = 3'd2;
	localparam logic [2:0] OP_CANCEL = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DRAG = 2'd1;
	localparam logic [1:0] PH_SNAP = 2'd2;

	localparam logic [1:0] CFG_GAIN   = 2'd0;
	localparam logic [1:0] CFG_DAMP   = 2'd1;
	localparam logic [1:0] CFG_DETACH = 2'd2;

	localparam logic [15:0] GAIN_RST   = 16'd13107;
	localparam logic [15:0] DAMP_RST   = 16'd52429;
	localparam logic [22:0] DETACH_RST = 23'd25600;

	localparam logic [4:0] U_NOP    = 5'd0;
	localparam logic [4:0] U_START  = 5'd1;
	localparam logic [4:0] U_UPDATE = 5'd2;
	localparam logic [4:0] U_CANCEL = 5'd3;
	localparam logic [4:0] U_DIFF   = 5'd4;
	localparam logic [4:0] U_SQ     = 5'd5;
	localparam logic [4:0] U_ACC    = 5'd6;
	localparam logic [4:0] U_THR    = 5'd7;
	localparam logic [4:0] U_ENDFIN = 5'd8;
	localparam logic [4:0] U_MULK   = 5'd9;
	localparam logic [4:0] U_ADDV   = 5'd10;
	localparam logic [4:0] U_MULC   = 5'd11;
	localparam logic [4:0] U_WRV    = 5'd12;
	localparam logic [4:0] U_ADDP   = 5'd13;
	localparam logic [4:0] U_CMPN   = 5'd14;
	localparam logic [4:0] U_SETTLE = 5'd15;
	localparam logic [4:0] U_DONE   = 5'd16;

	localparam logic AX_X = 1'b0;
	localparam logic AX_Y = 1'b1;

	localparam logic [1:0] SA_POINT = 2'd0;
	localparam logic [1:0] SA_TGT   = 2'd1;
	localparam logic [1:0] SA_CUR   = 2'd2;
	localparam logic [1:0] SA_VEL   = 2'd3;

	localparam logic [1:0] SB_HOME = 2'd0;
	localparam logic [1:0] SB_CUR  = 2'd1;
	localparam logic [1:0] SB_ZERO = 2'd2;

	localparam logic [1:0] J_NONE   = 2'd0;
	localparam logic [1:0] J_ALWAYS = 2'd1;
	localparam logic [1:0] J_NSNAP  = 2'd2;

	localparam logic [UW-1:0] A_START  = 6'd0;
	localparam logic [UW-1:0] A_DONE   = 6'd1;
	localparam logic [UW-1:0] A_UPDATE = 6'd2;
	localparam logic [UW-1:0] A_CANCEL = 6'd3;
	localparam logic [UW-1:0] A_END    = 6'd4;
	localparam logic [UW-1:0] A_TICK   = 6'd12;

	typedef struct packed {
		logic [4:0]    uop;
		logic          axis;
		logic [1:0]    sa;
		logic [1:0]    sb;
		logic          clr;
		logic [1:0]    cond;
		logic [UW-1:0] target;
	} ctl_t;

	function automatic ctl_t mk(input logic [4:0] uop, input logic axis,
			input logic [1:0] sa, input logic [1:0] sb, input logic clr,
			input logic [1:0] cond, input logic [UW-1:0] target);
		ctl_t c;
		c.uop    = uop;
		c.axis   = axis;
		c.sa     = sa;
		c.sb     = sb;
		c.clr    = clr;
		c.cond   = cond;
		c.target = target;
		return c;
	endfunction

	function automatic ctl_t op(input logic [4:0] uop, input logic axis);
		return mk(uop, axis, SA_POINT, SB_HOME, 1'b0, J_NONE, A_DONE);
	endfunction

	function automatic ctl_t diff(input logic axis, input logic [1:0] sa,
			input logic [1:0] sb);
		return mk(U_DIFF, axis, sa, sb, 1'b0, J_NONE, A_DONE);
	endfunction

	function automatic ctl_t acc(input logic clr);
		return mk(U_ACC, AX_X, SA_POINT, SB_HOME, clr, J_NONE, A_DONE);
	endfunction

	function automatic ctl_t jmp(input logic [4:0] uop, input logic [1:0] cond);
		return mk(uop, AX_X, SA_POINT, SB_HOME, 1'b0, cond, A_DONE);
	endfunction

	// microprogram
	function automatic ctl_t ucode(input logic [UW-1:0] a);
		ctl_t c;
		case (a)
			6'd0: c = op(U_START, AX_X);
			6'd1: c = op(U_DONE, AX_X);
			6'd2: c = jmp(U_UPDATE, J_ALWAYS);
			6'd3: c = jmp(U_CANCEL, J_ALWAYS);
			// end: |point - home|^2 against threshold^2
			6'd4: c = diff(AX_X, SA_POINT, SB_HOME);
			6'd5: c = op(U_SQ, AX_X);
			6'd6: c = acc(1'b1);
			6'd7: c = diff(AX_Y, SA_POINT, SB_HOME);
			6'd8: c = op(U_SQ, AX_X);
			6'd9: c = acc(1'b0);
			6'd10: c = op(U_THR, AX_X);
			6'd11: c = jmp(U_ENDFIN, J_ALWAYS);
			// tick: spring integration, x then y
			6'd12: c = diff(AX_X, SA_TGT, SB_CUR);
			6'd13: c = op(U_MULK, AX_X);
			6'd14: c = op(U_ADDV, AX_X);
			6'd15: c = op(U_MULC, AX_X);
			6'd16: c = op(U_WRV, AX_X);
			6'd17: c = op(U_ADDP, AX_X);
			6'd18: c = diff(AX_Y, SA_TGT, SB_CUR);
			6'd19: c = op(U_MULK, AX_Y);
			6'd20: c = op(U_ADDV, AX_Y);
			6'd21: c = op(U_MULC, AX_Y);
			6'd22: c = op(U_WRV, AX_Y);
			6'd23: c = op(U_ADDP, AX_Y);
			6'd24: c = jmp(U_NOP, J_NSNAP);
			// settle check
			6'd25: c = diff(AX_X, SA_CUR, SB_HOME);
			6'd26: c = op(U_SQ, AX_X);
			6'd27: c = acc(1'b1);
			6'd28: c = diff(AX_Y, SA_CUR, SB_HOME);
			6'd29: c = op(U_SQ, AX_X);
			6'd30: c = acc(1'b0);
			6'd31: c = op(U_CMPN, AX_X);
			6'd32: c = diff(AX_X, SA_VEL, SB_ZERO);
			6'd33: c = op(U_SQ, AX_X);
			6'd34: c = acc(1'b1);
			6'd35: c = diff(AX_Y, SA_VEL, SB_ZERO);
			6'd36: c = op(U_SQ, AX_X);
			6'd37: c = acc(1'b0);
			6'd38: c = jmp(U_SETTLE, J_ALWAYS);
			default: c = op(U_DONE, AX_X);
		endcase
		return c;
	endfunction

	function automatic logic [UW-1:0] entry(input logic [2:0] opcode);
		logic [UW-1:0] a;
		case (opcode)
			OP_START:  a = A_START;
			OP_UPDATE: a = A_UPDATE;
			OP_END:    a = A_END;
			OP_CANCEL: a = A_CANCEL;
			OP_TICK:   a = A_TICK;
			default:   a = A_DONE;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/core/dst_dpath.sv =====
module dst_dpath import dst_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
	parameter int GAIN_FRAC_BITS  = GAIN_FRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	input  cmd_t cmd,
	input  cfg_t cfg,
	output res_t res
);

	localparam logic [PW-1:0] NEAR2 = PW'(1) << (2 * COORD_FRAC_BITS + 2);
	localparam logic [PW-1:0] SLOW2 = PW'(1) << (2 * COORD_FRAC_BITS - 2);
	localparam logic signed [SW-1:0] SMAX = $signed((SW'(1) << (CW - 1)) - SW'(1));
	localparam logic signed [SW-1:0] SMIN = ~SMAX;

	function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		if (v > SMAX)
			r = SMAX;
		else if (v < SMIN)
			r = SMIN;
		else
			r = v;
		return r[CW-1:0];
	endfunction

	function automatic logic signed [SW-1:0] sx(input logic signed [CW-1:0] v);
		return $signed({{(SW - CW){v[CW-1]}}, v});
	endfunction

	logic signed [CW-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic signed [CW-1:0] vel_x_q, vel_y_q, home_x_q, home_y_q;
	logic [1:0]           phase_q;
	logic                 spawned_q;

	logic signed [MW-1:0] t_q;
	logic [PW-1:0]        p_q, acc_q;
	logic                 neg_q, near_q;

	logic signed [CW-1:0] pt_a, tgt_a, cur_a, vel_a, home_a, opa, opb;
	logic signed [MW-1:0] dif;
	logic [MW-1:0]        tu, mag, ma, mb;
	logic [PW-1:0]        prod, frac;
	logic signed [SW-1:0] fpos, fs, vsum, psum;
	logic signed [CW-1:0] vsat, fsat, psat;

	always_comb begin
		pt_a   = ctl.axis ? cmd.point_y : cmd.point_x;
		tgt_a  = ctl.axis ? tgt_y_q : tgt_x_q;
		cur_a  = ctl.axis ? cur_y_q : cur_x_q;
		vel_a  = ctl.axis ? vel_y_q : vel_x_q;
		home_a = ctl.axis ? home_y_q : home_x_q;
		case (ctl.sa)
			SA_POINT: opa = pt_a;
			SA_TGT:   opa = tgt_a;
			SA_CUR:   opa = cur_a;
			SA_VEL:   opa = vel_a;
			default:  opa = pt_a;
		endcase
		case (ctl.sb)
			SB_HOME: opb = home_a;
			SB_CUR:  opb = cur_a;
			SB_ZERO: opb = '0;
			default: opb = '0;
		endcase
		dif = $signed({opa[CW-1], opa}) - $signed({opb[CW-1], opb});

		tu  = t_q;
		mag = tu[MW-1] ? (~tu + MW'(1)) : tu;
		case (ctl.uop)
			U_MULK: begin
				ma = mag;
				mb = MW'(cfg.spring_gain);
			end
			U_MULC: begin
				ma = mag;
				mb = MW'(cfg.damping_factor);
			end
			U_THR: begin
				ma = MW'(cfg.detach_distance);
				mb = MW'(cfg.detach_distance);
			end
			default: begin
				ma = mag;
				mb = mag;
			end
		endcase
		prod = PW'(ma) * PW'(mb);

		// truncation toward zero: shift the magnitude, then restore the sign
		frac = p_q >> GAIN_FRAC_BITS;
		fpos = $signed({{(SW - PW){1'b0}}, frac});
		fs   = neg_q ? -fpos : fpos;
		vsum = sx(vel_a) + fs;
		psum = sx(cur_a) + sx(vel_a);
		vsat = sat(vsum);
		fsat = sat(fs);
		psat = sat(psum);
	end

	always_ff @(posedge clk) begin
		case (ctl.uop)
			U_DIFF: t_q <= dif;
			U_ADDV: t_q <= $signed({vsat[CW-1], vsat});
			U_SQ, U_MULK, U_MULC, U_THR: begin
				p_q   <= prod;
				neg_q <= t_q[MW-1];
			end
			U_ACC:  acc_q <= (ctl.clr ? '0 : acc_q) + p_q;
			U_CMPN: near_q <= (acc_q < NEAR2);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			tgt_x_q   <= '0;
			tgt_y_q   <= '0;
			vel_x_q   <= '0;
			vel_y_q   <= '0;
			home_x_q  <= '0;
			home_y_q  <= '0;
			phase_q   <= PH_IDLE;
			spawned_q <= 1'b0;
		end else begin
			case (ctl.uop)
				U_START: begin
					home_x_q <= cmd.anchor_x;
					home_y_q <= cmd.anchor_y;
					cur_x_q  <= cmd.point_x;
					cur_y_q  <= cmd.point_y;
					tgt_x_q  <= cmd.point_x;
					tgt_y_q  <= cmd.point_y;
					vel_x_q  <= '0;
					vel_y_q  <= '0;
					phase_q  <= PH_DRAG;
				end
				U_UPDATE: begin
					if (phase_q == PH_DRAG) begin
						tgt_x_q <= cmd.point_x;
						tgt_y_q <= cmd.point_y;
					end
				end
				U_CANCEL: begin
					phase_q <= PH_SNAP;
					tgt_x_q <= home_x_q;
					tgt_y_q <= home_y_q;
				end
				U_ENDFIN: begin
					if (acc_q >= p_q) begin
						spawned_q <= 1'b1;
						phase_q   <= PH_IDLE;
						tgt_x_q   <= cmd.point_x;
						tgt_y_q   <= cmd.point_y;
					end else begin
						phase_q <= PH_SNAP;
						tgt_x_q <= home_x_q;
						tgt_y_q <= home_y_q;
					end
				end
				U_WRV: begin
					if (ctl.axis)
						vel_y_q <= fsat;
					else
						vel_x_q <= fsat;
				end
				U_ADDP: begin
					if (ctl.axis)
						cur_y_q <= psat;
					else
						cur_x_q <= psat;
				end
				U_SETTLE: begin
					if (near_q && (acc_q < SLOW2)) begin
						cur_x_q <= home_x_q;
						cur_y_q <= home_y_q;
						vel_x_q <= '0;
						vel_y_q <= '0;
						phase_q <= PH_IDLE;
					end
				end
				U_DONE: spawned_q <= 1'b0;
				default: ;
			endcase
		end
	end

	assign res.pos_x   = cur_x_q;
	assign res.pos_y   = cur_y_q;
	assign res.mode    = phase_q;
	assign res.spawned = spawned_q;

endmodule

// ===== rtl/core/damped_spring_tether_core.sv =====
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------
// cmd      | cmd_valid / cmd_stall  | cmd_t: opcode, point, anchor
// res      | res_valid / res_stall  | res_t: pos, mode, spawned
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One command at a time, run by the microcode sequencer over one shared
// 25x25 multiplier. A tick also runs the settle check while snapping back.
// cmd_stall is high while a command runs; a finished result waits in the
// output register, and the next command may run up to its last step meanwhile.
// Reset restores the register defaults and clears the sequencer and the tether
// state, but not the command, result or datapath scratch registers.
module damped_spring_tether_core import dst_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
	parameter int GAIN_FRAC_BITS  = GAIN_FRAC_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	cfg_t          cfg_q;
	cmd_t          cmd_q;
	res_t          res_q, dres;
	logic          busy_q, res_valid_q;
	logic [UW-1:0] upc_q;
	ctl_t          ctl_rom, ctl;
	logic          accept, fire, is_done, taken;

	assign accept  = cmd_valid && !busy_q;
	assign ctl_rom = ucode(upc_q);
	assign is_done = (ctl_rom.uop == U_DONE);
	assign fire    = busy_q && !(is_done && res_valid_q && res_stall);
	assign taken   = (ctl_rom.cond == J_ALWAYS) ||
	                 ((ctl_rom.cond == J_NSNAP) && (dres.mode != PH_SNAP));

	always_comb begin
		ctl = ctl_rom;
		if (!fire) begin
			ctl.uop  = U_NOP;
			ctl.cond = J_NONE;
		end
	end

	dst_dpath #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.cmd   (cmd_q),
		.cfg   (cfg_q),
		.res   (dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= A_DONE;
		end else if (accept) begin
			busy_q <= 1'b1;
			upc_q  <= entry(cmd.opcode);
		end else if (fire) begin
			if (is_done)
				busy_q <= 1'b0;
			else
				upc_q <= taken ? ctl_rom.target : upc_q + UW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			cmd_q <= cmd;
		if (fire && is_done)
			res_q <= dres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (fire && is_done)
			res_valid_q <= 1'b1;
		else if (res_valid_q && !res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spring_gain     <= GAIN_RST;
			cfg_q.damping_factor  <= DAMP_RST;
			cfg_q.detach_distance <= DETACH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GAIN:   cfg_q.spring_gain     <= cfg_data[15:0];
				CFG_DAMP:   cfg_q.damping_factor  <= cfg_data[15:0];
				CFG_DETACH: cfg_q.detach_distance <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cmd_stall = busy_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

endmodule
